### src/tsit_pkg.sv
// Shared constants and codes for the time series interpolation table.
package tsit_pkg;

    localparam int SAMPLE_DEPTH  = 1024;
    localparam int IDX_W         = $clog2(SAMPLE_DEPTH);
    localparam int CNT_W         = IDX_W + 1;
    localparam int FRACTION_BITS = 16;
    localparam int DIV_CNT_W     = $clog2(FRACTION_BITS);
    localparam int NUM_LANES     = 8;
    localparam int LANE_W        = $clog2(NUM_LANES);
    localparam int VAL_W         = 32;
    localparam int ROW_W         = NUM_LANES * VAL_W;

    localparam logic [1:0] ACT_CLEAR  = 2'd0;
    localparam logic [1:0] ACT_APPEND = 2'd1;
    localparam logic [1:0] ACT_QUERY  = 2'd2;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_REJECTED = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_NO_SERIES = 3'd3;
    localparam logic [2:0] ST_VX_ZERO  = 3'd4;

    localparam logic [2:0] CFG_INTERP    = 3'd0;
    localparam logic [2:0] CFG_BX_ENABLE = 3'd1;
    localparam logic [2:0] CFG_BX_OFFSET = 3'd2;
    localparam logic [2:0] CFG_BY_GAIN   = 3'd3;
    localparam logic [2:0] CFG_BZ_GAIN   = 3'd4;

    localparam int LANE_VX = 2;
    localparam int LANE_BX = 5;

endpackage

### src/time_series_interpolation_table.sv
// Top level of the time series interpolation table: sequencer, sample memories, shared datapath.
//
// A request is taken when start is high and busy is low; every request gives exactly one
// result, shown for a single cycle with done high, and the receiver cannot stall it. A clear
// or an unused action code ends in the dispatch step. An append adds a step for the
// rising-time check against the last stored sample when the table is not empty, and steps
// for the two products and the saturated sum when the bx rule is on, since its two 32x32
// products share one multiplier. A query ends in the dispatch step when the series is
// invalid; else it compares with the first and then the last time to clamp to the first or
// last sample. Otherwise a binary search finds the lower sample and holds it, or, with
// interpolation on, reads the bracketing pair, forms the fraction and then the eight values
// in place of the single output step. Each search step reads one time from the single read
// port of the time memory and compares the registered time, the fraction comes from a
// restoring divider at one bit per cycle, and the eight values go one at a time through a
// single multiplier and adder. The sample memories are not cleared; only entries below the
// sample count are ever used. All values are Q16.16.
module time_series_interpolation_table
    import tsit_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         action,
    input  logic signed [31:0] time_value,
    input  logic signed [31:0] density,
    input  logic signed [31:0] pressure,
    input  logic signed [31:0] vel_x,
    input  logic signed [31:0] vel_y,
    input  logic signed [31:0] vel_z,
    input  logic signed [31:0] mag_x,
    input  logic signed [31:0] mag_y,
    input  logic signed [31:0] mag_z,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    output logic               done,
    output logic [2:0]         status,
    output logic signed [31:0] out_density,
    output logic signed [31:0] out_pressure,
    output logic signed [31:0] out_vel_x,
    output logic signed [31:0] out_vel_y,
    output logic signed [31:0] out_vel_z,
    output logic signed [31:0] out_mag_x,
    output logic signed [31:0] out_mag_y,
    output logic signed [31:0] out_mag_z
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_A_LAST,
        S_BX1,
        S_BX2,
        S_BX3,
        S_A_WR,
        S_Q_FIRST,
        S_Q_LAST,
        S_SRCH,
        S_SRCH_CMP,
        S_HOLD_RD,
        S_HOLD_OUT,
        S_I_LO,
        S_I_HI,
        S_DIV,
        S_MUL,
        S_ADD
    } state_t;

    state_t state_reg;

    // Configuration registers.
    logic               interp_reg;
    logic               bx_en_reg;
    logic signed [31:0] bx_offset_reg;
    logic signed [31:0] by_gain_reg;
    logic signed [31:0] bz_gain_reg;

    // Table state.
    logic [CNT_W-1:0] count_reg;
    logic             bad_reg;

    // Request held for the duration of its work.
    logic [1:0]         act_reg;
    logic signed [31:0] tq_reg;
    logic [ROW_W-1:0]   vin_reg;

    // Search, division and interpolation registers.
    logic [IDX_W-1:0]         lo_reg;
    logic [IDX_W-1:0]         hi_reg;
    logic signed [31:0]       tlo_reg;
    logic [32:0]              den_reg;
    logic [32:0]              rem_reg;
    logic [FRACTION_BITS-1:0] frac_reg;
    logic [DIV_CNT_W-1:0]     div_cnt_reg;
    logic [LANE_W-1:0]        lane_reg;
    logic [ROW_W-1:0]         a_reg;
    logic [ROW_W-1:0]         b_reg;
    logic signed [63:0]       p1_reg;
    logic signed [63:0]       p2_reg;
    logic signed [49:0]       prod_reg;

    // Result registers.
    logic             done_reg;
    logic [2:0]       status_reg;
    logic [31:0]      res_reg [NUM_LANES];

    // Memories and their registered read data.
    logic [31:0]      time_mem   [SAMPLE_DEPTH];
    logic [ROW_W-1:0] sample_mem [SAMPLE_DEPTH];
    logic signed [31:0] t_q;
    logic [ROW_W-1:0] s_q;
    logic [IDX_W-1:0] rd_addr;
    logic             mem_we;

    // Combinational datapath.
    logic [IDX_W-1:0]   span;
    logic [IDX_W-1:0]   mid;
    logic               span_wide;
    logic [IDX_W-1:0]   last_idx;
    logic               sample_ok;
    logic signed [31:0] bx_mul_a;
    logic signed [31:0] bx_mul_b;
    logic signed [63:0] bx_prod;
    logic signed [64:0] psum;
    logic signed [49:0] bx_sum;
    logic [31:0]        bx_sat;
    logic [33:0]        rem_sh;
    logic               rem_ge;
    logic signed [31:0] a_lane;
    logic signed [31:0] b_lane;
    logic signed [32:0] diff_lane;
    logic signed [32:0] interp_val;

    assign last_idx  = IDX_W'(count_reg - CNT_W'(1));
    assign span      = hi_reg - lo_reg;
    assign span_wide = (span > IDX_W'(1));
    assign mid       = lo_reg + (span >> 1);

    assign sample_ok = ($signed(vin_reg[0*VAL_W +: VAL_W]) > 0)
                    && ($signed(vin_reg[1*VAL_W +: VAL_W]) > 0)
                    && (vin_reg[LANE_VX*VAL_W +: VAL_W] != '0);

    // The one multiplier of the bx rule: by_gain*mag_y first, then bz_gain*mag_z.
    assign bx_mul_a = (state_reg == S_BX1) ? by_gain_reg : bz_gain_reg;
    assign bx_mul_b = (state_reg == S_BX1) ? $signed(vin_reg[6*VAL_W +: VAL_W])
                                           : $signed(vin_reg[7*VAL_W +: VAL_W]);
    assign bx_prod  = 64'(bx_mul_a) * 64'(bx_mul_b);

    // The exact sum of both Q32.32 products equals the sum of their separately floored halves
    // plus the carry out of the low halves, so one arithmetic shift of the sum matches it.
    assign psum   = 65'(p1_reg) + 65'(p2_reg);
    assign bx_sum = 50'(psum >>> 16) + 50'(bx_offset_reg);
    always_comb
    begin
        if (bx_sum > 50'sd2147483647)
        begin
            bx_sat = 32'h7FFF_FFFF;
        end
        else if (bx_sum < -50'sd2147483648)
        begin
            bx_sat = 32'h8000_0000;
        end
        else
        begin
            bx_sat = bx_sum[31:0];
        end
    end

    assign rem_sh = {rem_reg, 1'b0};
    assign rem_ge = (rem_sh >= {1'b0, den_reg});

    assign a_lane     = a_reg[{lane_reg, 5'b0} +: VAL_W];
    assign b_lane     = b_reg[{lane_reg, 5'b0} +: VAL_W];
    assign diff_lane  = 33'(b_lane) - 33'(a_lane);
    assign interp_val = 33'(a_lane) + 33'(prod_reg >>> FRACTION_BITS);

    // Read address for both memories, chosen by the step that issues the read.
    always_comb
    begin
        case (state_reg)
            S_DISPATCH: rd_addr = (act_reg == ACT_QUERY) ? '0 : last_idx;
            S_Q_FIRST:  rd_addr = last_idx;
            S_SRCH:     rd_addr = span_wide ? mid : lo_reg;
            S_I_LO:     rd_addr = lo_reg + IDX_W'(1);
            default:    rd_addr = lo_reg;
        endcase
    end

    assign mem_we = (state_reg == S_A_WR);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            time_mem[count_reg[IDX_W-1:0]]   <= tq_reg;
            sample_mem[count_reg[IDX_W-1:0]] <= vin_reg;
        end
        t_q <= time_mem[rd_addr];
        s_q <= sample_mem[rd_addr];
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interp_reg    <= 1'b1;
            bx_en_reg     <= 1'b0;
            bx_offset_reg <= '0;
            by_gain_reg   <= '0;
            bz_gain_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_INTERP:    interp_reg    <= cfg_data[0];
                CFG_BX_ENABLE: bx_en_reg     <= cfg_data[0];
                CFG_BX_OFFSET: bx_offset_reg <= cfg_data;
                CFG_BY_GAIN:   by_gain_reg   <= cfg_data;
                CFG_BZ_GAIN:   bz_gain_reg   <= cfg_data;
                default:       ;
            endcase
        end
    end

    // Sequencer with its registered results.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            bad_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        act_reg <= action;
                        tq_reg  <= time_value;
                        vin_reg <= {mag_z, mag_y, mag_x, vel_z, vel_y, vel_x, pressure, density};
                        status_reg <= ST_OK;
                        for (int i = 0; i < NUM_LANES; i++)
                        begin
                            res_reg[i] <= '0;
                        end
                        state_reg <= S_DISPATCH;
                    end
                end
                S_DISPATCH:
                begin
                    case (act_reg)
                        ACT_CLEAR:
                        begin
                            count_reg <= '0;
                            bad_reg   <= 1'b0;
                            done_reg  <= 1'b1;
                            state_reg <= S_IDLE;
                        end
                        ACT_APPEND:
                        begin
                            if (bad_reg)
                            begin
                                status_reg <= ST_NO_SERIES;
                                done_reg   <= 1'b1;
                                state_reg  <= S_IDLE;
                            end
                            else if (count_reg == CNT_W'(SAMPLE_DEPTH))
                            begin
                                bad_reg    <= 1'b1;
                                status_reg <= ST_FULL;
                                done_reg   <= 1'b1;
                                state_reg  <= S_IDLE;
                            end
                            else if (!sample_ok)
                            begin
                                bad_reg    <= 1'b1;
                                status_reg <= ST_REJECTED;
                                done_reg   <= 1'b1;
                                state_reg  <= S_IDLE;
                            end
                            else if (count_reg != '0)
                            begin
                                state_reg <= S_A_LAST;
                            end
                            else
                            begin
                                state_reg <= bx_en_reg ? S_BX1 : S_A_WR;
                            end
                        end
                        ACT_QUERY:
                        begin
                            if (bad_reg || (count_reg == '0))
                            begin
                                status_reg <= ST_NO_SERIES;
                                done_reg   <= 1'b1;
                                state_reg  <= S_IDLE;
                            end
                            else
                            begin
                                state_reg <= S_Q_FIRST;
                            end
                        end
                        default:
                        begin
                            done_reg  <= 1'b1;
                            state_reg <= S_IDLE;
                        end
                    endcase
                end
                S_A_LAST:
                begin
                    if (tq_reg > t_q)
                    begin
                        state_reg <= bx_en_reg ? S_BX1 : S_A_WR;
                    end
                    else
                    begin
                        bad_reg    <= 1'b1;
                        status_reg <= ST_REJECTED;
                        done_reg   <= 1'b1;
                        state_reg  <= S_IDLE;
                    end
                end
                S_BX1:
                begin
                    p1_reg    <= bx_prod;
                    state_reg <= S_BX2;
                end
                S_BX2:
                begin
                    p2_reg    <= bx_prod;
                    state_reg <= S_BX3;
                end
                S_BX3:
                begin
                    vin_reg[LANE_BX*VAL_W +: VAL_W] <= bx_sat;
                    state_reg <= S_A_WR;
                end
                S_A_WR:
                begin
                    count_reg <= count_reg + CNT_W'(1);
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                S_Q_FIRST:
                begin
                    if ((count_reg == CNT_W'(1)) || (tq_reg <= t_q))
                    begin
                        lo_reg    <= '0;
                        state_reg <= S_HOLD_RD;
                    end
                    else
                    begin
                        state_reg <= S_Q_LAST;
                    end
                end
                S_Q_LAST:
                begin
                    if (tq_reg >= t_q)
                    begin
                        lo_reg    <= last_idx;
                        state_reg <= S_HOLD_RD;
                    end
                    else
                    begin
                        lo_reg    <= '0;
                        hi_reg    <= last_idx;
                        state_reg <= S_SRCH;
                    end
                end
                S_SRCH:
                begin
                    if (span_wide)
                    begin
                        state_reg <= S_SRCH_CMP;
                    end
                    else if (!interp_reg)
                    begin
                        state_reg <= S_HOLD_OUT;
                    end
                    else
                    begin
                        state_reg <= S_I_LO;
                    end
                end
                S_SRCH_CMP:
                begin
                    if (t_q <= tq_reg)
                    begin
                        lo_reg <= mid;
                    end
                    else
                    begin
                        hi_reg <= mid;
                    end
                    state_reg <= S_SRCH;
                end
                S_HOLD_RD:
                begin
                    state_reg <= S_HOLD_OUT;
                end
                S_HOLD_OUT:
                begin
                    for (int i = 0; i < NUM_LANES; i++)
                    begin
                        res_reg[i] <= s_q[i*VAL_W +: VAL_W];
                    end
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                S_I_LO:
                begin
                    tlo_reg   <= t_q;
                    a_reg     <= s_q;
                    state_reg <= S_I_HI;
                end
                S_I_HI:
                begin
                    b_reg       <= s_q;
                    den_reg     <= 33'(t_q) - 33'(tlo_reg);
                    rem_reg     <= 33'(tq_reg) - 33'(tlo_reg);
                    div_cnt_reg <= '0;
                    state_reg   <= S_DIV;
                end
                S_DIV:
                begin
                    // One quotient bit per cycle; the remainder stays below the divisor.
                    if (rem_ge)
                    begin
                        rem_reg <= 33'(rem_sh - {1'b0, den_reg});
                    end
                    else
                    begin
                        rem_reg <= rem_sh[32:0];
                    end
                    frac_reg    <= {frac_reg[FRACTION_BITS-2:0], rem_ge};
                    div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
                    if (div_cnt_reg == DIV_CNT_W'(FRACTION_BITS - 1))
                    begin
                        lane_reg  <= '0;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    prod_reg  <= 50'($signed({1'b0, frac_reg}) * diff_lane);
                    state_reg <= S_ADD;
                end
                S_ADD:
                begin
                    res_reg[lane_reg] <= interp_val[31:0];
                    if (lane_reg == LANE_W'(NUM_LANES - 1))
                    begin
                        status_reg <= (res_reg[LANE_VX] == '0) ? ST_VX_ZERO : ST_OK;
                        done_reg   <= 1'b1;
                        state_reg  <= S_IDLE;
                    end
                    else
                    begin
                        lane_reg  <= lane_reg + LANE_W'(1);
                        state_reg <= S_MUL;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign status       = status_reg;
    assign out_density  = res_reg[0];
    assign out_pressure = res_reg[1];
    assign out_vel_x    = res_reg[2];
    assign out_vel_y    = res_reg[3];
    assign out_vel_z    = res_reg[4];
    assign out_mag_x    = res_reg[5];
    assign out_mag_y    = res_reg[6];
    assign out_mag_z    = res_reg[7];

`ifndef NO_ASSERTIONS
    // A result is only shown once the sequencer is free again.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result shown while busy");

    // An accepted request always takes the sequencer away from idle before its result.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("accepted request did not start work");

    // The sample count never passes the table depth.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(SAMPLE_DEPTH))
        else $error("sample count beyond depth");

    // Only a completed append grows the table, by exactly one.
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) && $past(rst_n)
        |-> (count_reg == '0) || (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("sample count changed by an illegal step");
`endif

endmodule
